/* hdl/tpm_pkg.sv */
package tpm_pkg;

    // Width of the internal tick counter; period_count shows its low 32 bits
    localparam int COUNT_WIDTH  = 32;
    localparam int PERIOD_WIDTH = 32;
    localparam int EDGE_WIDTH   = 8;

    localparam logic [EDGE_WIDTH-1:0] EDGES_RESET = EDGE_WIDTH'(1);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_RUN1 = 2'd2,
        PH_RUN2 = 2'd3
    } phase_t;

    typedef struct packed {
        logic trigger;
        logic enable;
    } item_t;

    typedef struct packed {
        logic                    from_first_counter;
        logic [PERIOD_WIDTH-1:0] period_count;
    } result_t;

endpackage

/* hdl/tpm_in_stage.sv */
module tpm_in_stage
    import tpm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  item_valid,
    output item_t item,
    input  logic  take
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Refill whenever the held item leaves or the register is empty
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_valid || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hdl/tpm_core.sv */
module tpm_core
    import tpm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [EDGE_WIDTH-1:0] cfg_edges,
    input  logic                  item_valid,
    input  item_t                 item,
    input  logic                  out_space,
    output logic                  take,
    output logic                  emit,
    output result_t               result
);

    phase_t                   phase_reg;
    phase_t                   phase_next;
    logic [COUNT_WIDTH-1:0]   tick_count_reg;
    logic [COUNT_WIDTH-1:0]   tick_count_next;
    logic [EDGE_WIDTH-1:0]    edges_left_reg;
    logic [EDGE_WIDTH-1:0]    edges_left_next;
    logic                     last_trigger_reg;
    logic [EDGE_WIDTH-1:0]    edges_per_measure_reg;

    logic                     edge_seen;
    logic                     running;
    logic                     hit;
    logic [EDGE_WIDTH-1:0]    edges_dec;
    logic [COUNT_WIDTH-1:0]   tick_inc;
    logic [COUNT_WIDTH+PERIOD_WIDTH-1:0] tick_ext;
    logic                     wants_emit;

    assign edge_seen = item.trigger && !last_trigger_reg;
    assign running   = (phase_reg == PH_RUN1) || (phase_reg == PH_RUN2);
    assign edges_dec = edges_left_reg - EDGE_WIDTH'(1);
    assign hit       = (edges_dec == '0);
    assign tick_inc  = tick_count_reg + COUNT_WIDTH'(1);
    assign tick_ext  = {{PERIOD_WIDTH{1'b0}}, tick_inc};

    assign wants_emit = running && edge_seen && hit;
    // An item with no result never waits on the output side
    assign take = item_valid && (!wants_emit || out_space);
    assign emit = take && wants_emit;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (item.enable)
                begin
                    phase_next = PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                if (!item.enable)
                begin
                    phase_next = PH_IDLE;
                end
                else if (edge_seen)
                begin
                    phase_next = PH_RUN1;
                end
            end
            PH_RUN1, PH_RUN2:
            begin
                if (!item.enable)
                begin
                    phase_next = PH_IDLE;
                end
                else if (wants_emit)
                begin
                    phase_next = (phase_reg == PH_RUN1) ? PH_RUN2 : PH_RUN1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Counters and result
    always_comb
    begin
        tick_count_next = tick_count_reg;
        edges_left_next = edges_left_reg;
        case (phase_reg)
            PH_WAIT:
            begin
                if (edge_seen)
                begin
                    tick_count_next = '0;
                    edges_left_next = edges_per_measure_reg;
                end
            end
            PH_RUN1, PH_RUN2:
            begin
                tick_count_next = tick_inc;
                if (edge_seen)
                begin
                    edges_left_next = hit ? edges_per_measure_reg : edges_dec;
                end
                if (wants_emit || !item.enable)
                begin
                    tick_count_next = '0;
                end
            end
            default:
            begin
                tick_count_next = tick_count_reg;
            end
        endcase
        result.period_count       = tick_ext[PERIOD_WIDTH-1:0];
        result.from_first_counter = (phase_reg == PH_RUN1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            tick_count_reg   <= '0;
            edges_left_reg   <= '0;
            last_trigger_reg <= 1'b0;
        end
        else if (take)
        begin
            phase_reg        <= phase_next;
            tick_count_reg   <= tick_count_next;
            edges_left_reg   <= edges_left_next;
            last_trigger_reg <= item.trigger;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edges_per_measure_reg <= EDGES_RESET;
        end
        else if (cfg_write)
        begin
            edges_per_measure_reg <= cfg_edges;
        end
    end

    a_drop_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take && !item.enable |=> phase_reg == PH_IDLE)
        else $error("phase did not return to idle after enable dropped");

    a_count_clear_outside_run: assert property (@(posedge clk) disable iff (!rst_n)
        !running |-> tick_count_reg == '0)
        else $error("tick count not clear outside the counting phases");

    a_emit_swaps: assert property (@(posedge clk) disable iff (!rst_n)
        emit && item.enable && phase_reg == PH_RUN1 |=> phase_reg == PH_RUN2)
        else $error("first counter phase did not swap after a result");

    a_emit_needs_space: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_space)
        else $error("result produced with no room in the output register");

endmodule

/* hdl/tpm_out_stage.sv */
module tpm_out_stage
    import tpm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_result,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign space      = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

/* hdl/tacho_period_meter_top.sv */
// Tachometer period meter. Each transfer on the input stream is one sampled tick
// of the tacho trigger together with the enable level; one transfer per clock
// cycle is sustained unless a due result finds no output room; a tick passes
// one input register and one result register. Raising enable arms the meter, the
// first rising trigger edge starts counting ticks, and after every
// edges_per_measure further edges (0 means 256) the tick count is sent out and
// counting restarts, alternating between the first and second counter phase;
// tuser flags a result that ends the first phase. Dropping enable stops the
// measurement and returns to idle, though a result due on that same tick is
// still sent. The count wraps at its width. Write edges_per_measure only while
// the stream is idle; a new value takes effect at the next reload of the edge
// count. Its reset value is 1.
module tacho_period_meter_top
    import tpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,       // [7:0] edges_per_measure

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] enable, [1] trigger, [7:2] zero

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] period_count
    output logic [0:0]  m_axis_tuser    // [0] from_first_counter
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    logic    emit;
    logic    out_space;
    result_t core_result;
    result_t out_result;

    // Configuration writes never stall
    assign cfg_ready = 1'b1;

    assign in_item.enable  = s_axis_tdata[0];
    assign in_item.trigger = s_axis_tdata[1];

    // Hold one input tick ahead of the state update
    tpm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .take       (take)
    );

    // Advance the phase and counters once per tick; ticks without a result
    // keep flowing even while a finished result waits downstream
    tpm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_edges  (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .out_space  (out_space),
        .take       (take),
        .emit       (emit),
        .result     (core_result)
    );

    // Hold the result until the output transfer completes
    tpm_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (emit),
        .load_result (core_result),
        .space       (out_space),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (out_result)
    );

    assign m_axis_tdata    = out_result.period_count;
    assign m_axis_tuser[0] = out_result.from_first_counter;

endmodule
